FILE: rtl/core/hlg_pkg.sv
// ---------------------------------------------------------------------------
// hlg_pkg
// Widths, constants and shared types of the Huber loss gradient unit.
// ---------------------------------------------------------------------------
package hlg_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_COUNT   = 65536;
   localparam int DELTA_W     = 15;
   localparam int DELTA_RESET = 256;
   localparam int GRAD_W      = 17;
   localparam int MEAN_W      = 31;
   localparam int SUM_W       = 48;

   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int ABS_W       = SAMPLE_W;
   localparam int OP_W        = (ABS_W > DELTA_W) ? ABS_W : DELTA_W;
   localparam int PROD_W      = 2 * OP_W;
   localparam int DSQ_W       = 2 * DELTA_W;
   localparam int HDSQ_RESET  = (DELTA_RESET * DELTA_RESET + 1) / 2;
   localparam int COUNT_W     = $clog2(MAX_COUNT + 1);
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [GRAD_W-1:0] gradient;
      logic [OP_W-1:0]          mul_a;
      logic [OP_W-1:0]          mul_b;
      logic                     in_band;
      logic                     last;
   } hlg_item_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } hlg_div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } hlg_div_rsp_type;

endpackage

FILE: rtl/core/hlg_if.sv
// ---------------------------------------------------------------------------
// hlg_if
// Request and response channels of the Huber loss gradient unit.
// ---------------------------------------------------------------------------
interface hlg_req_if import hlg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] predicted;
   logic signed [SAMPLE_W-1:0] truth;
   logic                       last;

   modport source (output valid, output predicted, output truth, output last, input ready);
   modport sink (input valid, input predicted, input truth, input last, output ready);
endinterface

interface hlg_rsp_if import hlg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] gradient;
   logic [MEAN_W-1:0]        loss_mean;
   logic                     loss_valid;

   modport source (output valid, output gradient, output loss_mean, output loss_valid,
                   input ready);
   modport sink (input valid, input gradient, input loss_mean, input loss_valid,
                 output ready);
endinterface

FILE: rtl/core/huber_loss_gradient_unit.sv
// ---------------------------------------------------------------------------
// huber_loss_gradient_unit
// Huber loss gradient over a stream of predicted and true Q8.8 values,
// with the mean batch loss in Q15.16 on the last request of each batch.
// ---------------------------------------------------------------------------
// The front takes a request in the cycle it arrives as long as its four-entry
// queue has room. The back handles one request at a time: fetch, multiply,
// accumulate, load of the response register, waiting while that register is
// still held. A request marked last adds the bit-serial division of the 48-bit
// loss sum by the element count. The user must write delta through csr_we and
// csr_wdata only while no request is in flight; the block does not enforce it.
module huber_loss_gradient_unit import hlg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   hlg_req_if.sink            req_ch,
   hlg_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  logic [DELTA_W-1:0] csr_wdata
);

   logic [DELTA_W-1:0] delta_ff;
   logic [DSQ_W-1:0]   half_dsq_ff, half_dsq_in;
   logic [DSQ_W-1:0]   dsq;
   logic [DSQ_W:0]     dsq_rnd;

   hlg_item_type       front_item;
   hlg_item_type       queue_item;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;
   hlg_div_req_type    div_req;
   hlg_div_rsp_type    div_rsp;

   // half of delta squared, rounded up
   always_comb begin
      dsq         = DSQ_W'(csr_wdata) * DSQ_W'(csr_wdata);
      dsq_rnd     = {1'b0, dsq} + (DSQ_W+1)'(1);
      half_dsq_in = dsq_rnd[DSQ_W:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff    <= DELTA_W'(DELTA_RESET);
         half_dsq_ff <= DSQ_W'(HDSQ_RESET);
      end else if (csr_we) begin
         delta_ff    <= csr_wdata;
         half_dsq_ff <= half_dsq_in;
      end
   end

   hlg_front u_front (
      .req_ch     (req_ch),
      .delta      (delta_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (front_item)
   );

   hlg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (pop),
      .item_out (queue_item),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   hlg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   hlg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (queue_item),
      .queue_empty (queue_empty),
      .half_dsq    (half_dsq_ff),
      .div_rsp     (div_rsp),
      .pop         (pop),
      .div_req     (div_req),
      .rsp_ch      (rsp_ch)
   );

endmodule

FILE: rtl/core/hlg_front.sv
// ---------------------------------------------------------------------------
// hlg_front
// Accepts requests, forms the difference and classifies it against delta.
// ---------------------------------------------------------------------------
module hlg_front import hlg_pkg::*; (
   hlg_req_if.sink            req_ch,
   input  logic [DELTA_W-1:0] delta,
   input  logic               queue_full,
   output logic               push,
   output hlg_item_type       item
);

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_abs;
   logic [ABS_W-1:0]         mag;
   logic                     in_band;
   logic [GRAD_W-1:0]        delta_ext;

   assign diff      = DIFF_W'(req_ch.predicted) - DIFF_W'(req_ch.truth);
   assign diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign mag       = diff_abs[ABS_W-1:0];
   assign in_band   = OP_W'(mag) < OP_W'(delta);
   assign delta_ext = GRAD_W'(delta);

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      item.in_band = in_band;
      item.last    = req_ch.last;
      item.mul_b   = OP_W'(mag);
      if (in_band) begin
         item.gradient = GRAD_W'(diff);
         item.mul_a    = OP_W'(mag);
      end else begin
         item.gradient = diff[DIFF_W-1] ? $signed(-delta_ext) : $signed(delta_ext);
         item.mul_a    = OP_W'(delta);
      end
   end

endmodule

FILE: rtl/core/hlg_queue.sv
// ---------------------------------------------------------------------------
// hlg_queue
// Short queue of classified requests between front and back.
// ---------------------------------------------------------------------------
module hlg_queue import hlg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hlg_item_type item_in,
   input  logic         pop,
   output hlg_item_type item_out,
   output logic         full,
   output logic         empty
);

   hlg_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_pop;

   assign full     = fill_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_pop   = pop && !empty;
   assign item_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/core/hlg_div.sv
// ---------------------------------------------------------------------------
// hlg_div
// Restoring divider, one quotient bit per cycle, for the batch mean.
// ---------------------------------------------------------------------------
module hlg_div import hlg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  hlg_div_req_type div_req,
   output hlg_div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   divisor_ff;
   logic [COUNT_W:0]     trial;
   logic                 ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      ge     = trial >= {1'b0, divisor_ff};
      rem_in = ge ? COUNT_W'(trial - {1'b0, divisor_ff}) : trial[COUNT_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], ge};
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= DIV_CNT_W'(SUM_W);
            quo_ff     <= div_req.dividend;
            rem_ff     <= '0;
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

FILE: rtl/core/hlg_back.sv
// ---------------------------------------------------------------------------
// hlg_back
// Computes the element loss, keeps the batch sum and count, forms the mean
// and holds the response register.
// ---------------------------------------------------------------------------
module hlg_back import hlg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  hlg_item_type     item,
   input  logic             queue_empty,
   input  logic [DSQ_W-1:0] half_dsq,
   input  hlg_div_rsp_type  div_rsp,
   output logic             pop,
   output hlg_div_req_type  div_req,
   hlg_rsp_if.source        rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   hlg_item_type             item_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [PROD_W-1:0]        eloss;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SUM_W:0]           sum_wide;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [GRAD_W-1:0] grad_pend_ff;
   logic [MEAN_W-1:0]        mean_pend_ff;
   logic                     lvalid_pend_ff;
   logic [MEAN_W-1:0]        mean_sat;
   logic                     rsp_valid_ff;
   logic signed [GRAD_W-1:0] rsp_grad_ff;
   logic [MEAN_W-1:0]        rsp_mean_ff;
   logic                     rsp_lvalid_ff;

   always_comb begin
      eloss    = item_ff.in_band ? (prod_ff >> 1) : (prod_ff - PROD_W'(half_dsq));
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(eloss);
      sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      count_in = (count_ff < COUNT_W'(MAX_COUNT)) ? count_ff + 1'b1 : count_ff;
      mean_sat = (div_rsp.quotient[SUM_W-1:MEAN_W] != '0) ? '1
                                                           : div_rsp.quotient[MEAN_W-1:0];
   end

   assign pop              = (state_ff == ST_IDLE) && !queue_empty;
   assign div_req.start    = (state_ff == ST_ACC) && item_ff.last;
   assign div_req.dividend = sum_in;
   assign div_req.divisor  = count_in;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.gradient   = rsp_grad_ff;
   assign rsp_ch.loss_mean  = rsp_mean_ff;
   assign rsp_ch.loss_valid = rsp_lvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  item_ff  <= item;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= item_ff.mul_a * item_ff.mul_b;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               grad_pend_ff <= item_ff.gradient;
               if (item_ff.last) begin
                  sum_ff   <= '0;
                  count_ff <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  sum_ff         <= sum_in;
                  count_ff       <= count_in;
                  mean_pend_ff   <= '0;
                  lvalid_pend_ff <= 1'b0;
                  state_ff       <= ST_EMIT;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  mean_pend_ff   <= mean_sat;
                  lvalid_pend_ff <= 1'b1;
                  state_ff       <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_grad_ff   <= grad_pend_ff;
                  rsp_mean_ff   <= mean_pend_ff;
                  rsp_lvalid_ff <= lvalid_pend_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/hlg_checker.sv
// ---------------------------------------------------------------------------
// hlg_checker
// Port-level checks of the Huber loss gradient unit, bound to the top level.
// ---------------------------------------------------------------------------
module hlg_checker import hlg_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [GRAD_W-1:0] rsp_gradient,
   input logic [MEAN_W-1:0]        rsp_loss_mean,
   input logic                     rsp_loss_valid
);

   logic [3:0] outstanding_ff, outstanding_in;

   // requests taken but not yet answered
   assign outstanding_in = outstanding_ff + 4'(req_valid && req_ready)
                           - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_gradient) && $stable(rsp_loss_mean)
                                  && $stable(rsp_loss_valid))
      else $error("response payload changed while stalled");

   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_loss_valid |-> rsp_loss_mean == '0)
      else $error("loss mean nonzero without loss valid");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response without an outstanding request");

   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gradient != {1'b1, {(GRAD_W-1){1'b0}}})
      else $error("gradient out of range");

endmodule

bind huber_loss_gradient_unit hlg_checker u_hlg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_gradient   (rsp_ch.gradient),
   .rsp_loss_mean  (rsp_ch.loss_mean),
   .rsp_loss_valid (rsp_ch.loss_valid)
);

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for huber_loss_gradient_unit. Requests are drawn from a
// queue, each accepted request is run through a cycle-free Huber gradient and
// batch-loss model, and every response is compared field by field in order.
// Directed corners at several thresholds come first, then random batches
// under changing delta settings with random idling on both channels in some
// phases, then a short batch with delta at zero.
// ---------------------------------------------------------------------------
module testbench;
   import hlg_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 250;
   localparam logic [DELTA_W-1:0] DELTA_MIN = DELTA_W'(1);
   localparam logic [DELTA_W-1:0] DELTA_MAX = '1;
   localparam longint unsigned SUM_MAX  = (64'd1 << SUM_W) - 64'd1;
   localparam longint unsigned MEAN_MAX = (64'd1 << MEAN_W) - 64'd1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] predicted;
      logic signed [SAMPLE_W-1:0] truth;
      logic                       last;
   } huber_sample_type;

   typedef struct {
      logic signed [GRAD_W-1:0] gradient;
      logic [MEAN_W-1:0]        loss_mean;
      logic                     loss_valid;
   } huber_result_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [DELTA_W-1:0] csr_wdata;

   hlg_req_if req_ch ();
   hlg_rsp_if rsp_ch ();

   huber_loss_gradient_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   huber_sample_type   sample_queue[$];
   huber_result_type   gradient_fifo[$];
   logic [DELTA_W-1:0] threshold;
   longint unsigned    loss_sum;
   int                 sample_count;
   bit                 req_idle;
   bit                 rsp_idle;
   int                 gap_left;
   int                 stall_left;
   int                 queued_total;
   int                 results_seen;
   int                 error_count;
   int                 batch_total;
   int                 delta_writes;
   int                 cycle_count;
   huber_sample_type   taken;
   huber_sample_type   next_sample;
   huber_result_type   want;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic huber_result_type huber_step(huber_sample_type s);
      huber_result_type r;
      longint           diff;
      longint           mag;
      longint           thr;
      longint unsigned  eloss;
      longint unsigned  mean;
      thr  = longint'(threshold);
      diff = longint'(s.predicted) - longint'(s.truth);
      mag  = (diff < 0) ? -diff : diff;
      if (mag < thr) begin
         r.gradient = GRAD_W'(diff);
         eloss      = (mag * mag) >> 1;
      end else begin
         r.gradient = GRAD_W'((s.predicted < s.truth) ? -thr : thr);
         eloss      = (2 * thr * mag - thr * thr) >> 1;
      end
      if (eloss > SUM_MAX - loss_sum) begin
         loss_sum = SUM_MAX;
      end else begin
         loss_sum = loss_sum + eloss;
      end
      if (sample_count < MAX_COUNT) begin
         sample_count++;
      end
      r.loss_mean  = '0;
      r.loss_valid = 1'b0;
      if (s.last) begin
         mean = loss_sum / longint'((sample_count == 0) ? 1 : sample_count);
         if (mean > MEAN_MAX) begin
            mean = MEAN_MAX;
         end
         r.loss_mean  = MEAN_W'(mean);
         r.loss_valid = 1'b1;
         loss_sum     = 0;
         sample_count = 0;
      end
      return r;
   endfunction

   function automatic int pick_idle(bit enabled, int rate);
      if (!enabled || $urandom_range(0, 99) >= rate) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(string field, logic signed [63:0] expv,
                                logic signed [63:0] actv);
      error_count++;
      if (error_count <= 40) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
      end
   endtask

   task automatic push_sample(int p, int t, bit last);
      huber_sample_type s;
      s.predicted = SAMPLE_W'(p);
      s.truth     = SAMPLE_W'(t);
      s.last      = last;
      sample_queue.push_back(s);
      queued_total++;
      if (last) begin
         batch_total++;
      end
   endtask

   task automatic push_random(bit last);
      logic signed [SAMPLE_W-1:0] p;
      logic signed [SAMPLE_W-1:0] t;
      longint                     off;
      longint                     v;
      t = SAMPLE_W'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            p = SAMPLE_W'($urandom);
         end
         1: begin
            // just around the threshold on either side
            off = longint'(threshold) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) off = -off;
            v = longint'(t) + off;
            if (v > 32767 || v < -32768) v = longint'(t) - off;
            p = SAMPLE_W'(v);
         end
         2: begin
            off = longint'($urandom_range(0, 2 * threshold)) - longint'(threshold);
            p   = SAMPLE_W'(longint'(t) + off);
         end
         default: begin
            p = {1'($urandom_range(0, 1)), {(SAMPLE_W - 1){1'($urandom_range(0, 1))}}};
            t = {1'($urandom_range(0, 1)), {(SAMPLE_W - 1){1'($urandom_range(0, 1))}}};
         end
      endcase
      push_sample(int'(p), int'(t), last);
   endtask

   task automatic drain();
      while (results_seen != queued_total) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_delta(logic [DELTA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      threshold = value;
      delta_writes++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.predicted <= '0;
         req_ch.truth     <= '0;
         req_ch.last      <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.predicted = req_ch.predicted;
            taken.truth     = req_ch.truth;
            taken.last      = req_ch.last;
            gradient_fifo.push_back(huber_step(taken));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               next_sample = sample_queue.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.predicted <= next_sample.predicted;
               req_ch.truth     <= next_sample.truth;
               req_ch.last      <= next_sample.last;
               gap_left = pick_idle(req_idle, 40);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (gradient_fifo.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, got gradient %0d",
                        $time, rsp_ch.gradient);
            end else begin
               want = gradient_fifo.pop_front();
               if (rsp_ch.gradient !== want.gradient)
                  flag_mismatch("gradient", want.gradient, rsp_ch.gradient);
               if (rsp_ch.loss_mean !== want.loss_mean)
                  flag_mismatch("loss_mean", want.loss_mean, rsp_ch.loss_mean);
               if (rsp_ch.loss_valid !== want.loss_valid)
                  flag_mismatch("loss_valid", want.loss_valid, rsp_ch.loss_valid);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left = pick_idle(rsp_idle, 20);
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  queued_total - results_seen);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int len;
      int n;
      bit paused;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.predicted = '0;
      req_ch.truth     = '0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      threshold        = DELTA_W'(DELTA_RESET);
      loss_sum         = 0;
      sample_count     = 0;
      req_idle         = 1'b1;
      rsp_idle         = 1'b1;
      queued_total     = 0;
      results_seen     = 0;
      error_count      = 0;
      batch_total      = 0;
      delta_writes     = 0;
      cycle_count      = 0;
      paused           = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset threshold, edges of the inside region and widest differences
      push_sample(0, 0, 1'b0);
      push_sample(255, 0, 1'b0);
      push_sample(256, 0, 1'b0);
      push_sample(0, 255, 1'b0);
      push_sample(0, 256, 1'b0);
      push_sample(32767, -32768, 1'b0);
      push_sample(-32768, 32767, 1'b1);
      push_sample(100, -3, 1'b1);
      drain();

      write_delta(DELTA_MIN);
      push_sample(0, 0, 1'b0);
      push_sample(1, 0, 1'b0);
      push_sample(-1, 0, 1'b0);
      push_sample(-32768, -32768, 1'b1);
      drain();

      write_delta(DELTA_MAX);
      push_sample(32766, 0, 1'b0);
      push_sample(32767, 0, 1'b0);
      push_sample(-32768, 0, 1'b0);
      push_sample(0, -32767, 1'b0);
      push_sample(-32768, 32767, 1'b1);
      push_sample(32767, -32768, 1'b1);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_delta(DELTA_MIN);
            1: write_delta(DELTA_MAX);
            2: write_delta(DELTA_W'(DELTA_RESET));
            3: write_delta(DELTA_W'($urandom_range(1, 64)));
            default: write_delta(DELTA_W'($urandom_range(1, 32767)));
         endcase
         req_idle = (phase != 0) && (phase != 4);
         rsp_idle = (phase != 0) && (phase != 2);
         n = 0;
         while (n < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 120);
            if (len > PHASE_ITEMS - n) len = PHASE_ITEMS - n;
            for (int k = 0; k < len; k++) push_random(k == len - 1);
            n += len;
            // sender holds off until everything in flight has come back
            if (phase == 3 && !paused && n >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               drain();
            end
         end
         drain();
      end

      // zero threshold puts every element outside the band
      write_delta(DELTA_W'(0));
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      for (int k = 0; k < 3; k++) push_random(k == 2);
      drain();

      repeat (60) @(posedge clock);
      if (gradient_fifo.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses expected but never seen", $time, gradient_fifo.size());
      end
      $display("checked %0d responses over %0d batches and %0d delta writes", results_seen,
               batch_total, delta_writes);
      $display("thresholds from zero to full scale, stalls on both sides; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
